@@ design/b85_pkg.sv @@
package b85_pkg;

  // FIFO depth between the byte front end and the digit back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // floor(n / 85) == (n * RECIP_85) >> RECIP_SHIFT for every 32-bit n
  localparam logic [31:0] RECIP_85    = 32'hC0C0C0C1;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [13:0] RADIX       = 14'd85;

  localparam int unsigned DIGITS_PER_GROUP = 5;

  localparam logic [1:0] ALPHA_ORIGINAL = 2'd0;
  localparam logic [1:0] ALPHA_Z85      = 2'd1;
  localparam logic [1:0] ALPHA_RFC1924  = 2'd2;

  // First character sits in the top byte
  localparam logic [85*8-1:0] Z85_STR =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
  localparam logic [85*8-1:0] RFC1924_STR =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_`{|}~";

  typedef enum logic [2:0] {
    REG_ALPHABET   = 3'd0,
    REG_ZERO_EN    = 3'd1,
    REG_ZERO_CHAR  = 3'd2,
    REG_SPACE_EN   = 3'd3,
    REG_SPACE_CHAR = 3'd4,
    REG_PADDING    = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    JOB_DIGITS,
    JOB_CHAR,
    JOB_ERROR
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] value;     // group value, or the single character in [7:0]
    logic [2:0]  n_chars;   // characters to send, 1..5
    logic        stream_end;
  } job_t;

  typedef struct packed {
    logic [1:0] alphabet_select;
    logic       zero_en;
    logic [7:0] zero_char;
    logic       space_en;
    logic [7:0] space_char;
    logic       padding_en;
  } cfg_t;

  function automatic logic [7:0] b85_char(input logic [1:0] sel, input logic [6:0] digit);
    logic [9:0] pos;
    logic [7:0] ch;
    pos = {7'd84 - digit, 3'b000};
    case (sel)
      ALPHA_Z85:     ch = Z85_STR[pos +: 8];
      ALPHA_RFC1924: ch = RFC1924_STR[pos +: 8];
      default:       ch = {1'b0, digit} + 8'd33;
    endcase
    return ch;
  endfunction

endpackage

@@ design/b85_front.sv @@
module b85_front
  import b85_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_stream_end,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic [23:0] group_bytes_r, group_bytes_nxt;
  logic [1:0]  group_count_r, group_count_nxt;
  logic [2:0]  n;
  logic [31:0] acc;
  logic        accept;
  logic        group_done;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign n          = {1'b0, group_count_r} + 3'd1;
  assign acc        = {group_bytes_r, in_data_byte};
  assign group_done = (n == 3'd4) || in_stream_end;
  assign push       = accept && group_done;

  // Classify the finished group
  always_comb begin
    push_job.kind       = JOB_DIGITS;
    push_job.value      = acc;
    push_job.n_chars    = n + 3'd1;
    push_job.stream_end = in_stream_end;
    if (n == 3'd4) begin
      if (acc == 32'h0000_0000 && cfg.zero_en) begin
        push_job.kind    = JOB_CHAR;
        push_job.value   = {24'd0, cfg.zero_char};
        push_job.n_chars = 3'd1;
      end else if (acc == 32'h2020_2020 && cfg.space_en) begin
        push_job.kind    = JOB_CHAR;
        push_job.value   = {24'd0, cfg.space_char};
        push_job.n_chars = 3'd1;
      end
    end else if (!cfg.padding_en) begin
      push_job.kind    = JOB_ERROR;
      push_job.value   = 32'd0;
      push_job.n_chars = 3'd1;
    end else begin
      // pad the partial group with zero bytes at the bottom
      case (n)
        3'd1:    push_job.value = {acc[7:0], 24'd0};
        3'd2:    push_job.value = {acc[15:0], 16'd0};
        3'd3:    push_job.value = {acc[23:0], 8'd0};
        default: push_job.value = acc;
      endcase
    end
  end

  always_comb begin
    group_bytes_nxt = group_bytes_r;
    group_count_nxt = group_count_r;
    if (accept) begin
      if (group_done) begin
        group_bytes_nxt = 24'd0;
        group_count_nxt = 2'd0;
      end else begin
        group_bytes_nxt = acc[23:0];
        group_count_nxt = n[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_bytes_r <= 24'd0;
      group_count_r <= 2'd0;
    end else begin
      group_bytes_r <= group_bytes_nxt;
      group_count_r <= group_count_nxt;
    end
  end

endmodule

@@ design/b85_queue.sv @@
module b85_queue
  import b85_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ design/b85_back.sv @@
module b85_back
  import b85_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_stream_done,
  output logic       out_pad_error
);

  // divider stage
  logic        d_full_r, d_full_nxt;
  logic        d_fin_r, d_fin_nxt;
  logic [1:0]  d_step_r, d_step_nxt;
  logic [31:0] d_v_r, d_v_nxt;
  logic [6:0]  d_dg_r [DIGITS_PER_GROUP];
  job_kind_t   d_kind_r;
  logic [2:0]  d_nchars_r;
  logic [7:0]  d_char_r;
  logic        d_end_r;

  // emit stage
  logic        e_full_r, e_full_nxt;
  logic [2:0]  e_idx_r, e_idx_nxt;
  logic [6:0]  e_dg_r [DIGITS_PER_GROUP];
  job_kind_t   e_kind_r;
  logic [2:0]  e_nchars_r;
  logic [7:0]  e_char_r;
  logic        e_end_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r;
  logic        out_run_last_r;
  logic        out_stream_done_r;
  logic        out_pad_error_r;

  logic [63:0] prod;
  logic [25:0] quo;
  logic [13:0] quo85;
  logic [6:0]  rem;
  logic        out_load;
  logic        e_last;
  logic        e_finish;
  logic        e_take;
  logic        handoff;
  logic        d_load;
  logic [6:0]  e_digit;
  logic [7:0]  e_out_char;

  // one divide-by-85 step per cycle, least significant digit first
  assign prod  = 64'(d_v_r) * 64'(RECIP_85);
  assign quo   = prod[63:RECIP_SHIFT];
  assign quo85 = 14'(quo[6:0]) * RADIX;
  assign rem   = d_v_r[6:0] - quo85[6:0];

  assign out_load = !out_valid_r || out_ready;
  assign e_last   = (e_idx_r == e_nchars_r - 3'd1);
  assign e_finish = e_full_r && out_load && e_last;
  assign e_take   = !e_full_r || e_finish;
  assign handoff  = d_full_r && d_fin_r && e_take;
  assign d_load   = !q_empty && (!d_full_r || handoff);
  assign q_pop    = d_load;

  always_comb begin
    d_full_nxt = d_full_r;
    d_fin_nxt  = d_fin_r;
    d_step_nxt = d_step_r;
    d_v_nxt    = d_v_r;
    if (d_load) begin
      d_full_nxt = 1'b1;
      d_fin_nxt  = (q_job.kind != JOB_DIGITS);
      d_step_nxt = 2'd0;
      d_v_nxt    = q_job.value;
    end else if (handoff) begin
      d_full_nxt = 1'b0;
    end else if (d_full_r && !d_fin_r) begin
      d_v_nxt    = 32'(quo);
      d_step_nxt = d_step_r + 2'd1;
      d_fin_nxt  = (d_step_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_full_r <= 1'b0;
      d_fin_r  <= 1'b0;
      d_step_r <= 2'd0;
    end else begin
      d_full_r <= d_full_nxt;
      d_fin_r  <= d_fin_nxt;
      d_step_r <= d_step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_v_r <= d_v_nxt;
    if (d_load) begin
      d_kind_r   <= q_job.kind;
      d_nchars_r <= q_job.n_chars;
      d_char_r   <= q_job.value[7:0];
      d_end_r    <= q_job.stream_end;
    end else if (d_full_r && !d_fin_r) begin
      // shift remainders toward the high index; slot 0 keeps the quotient
      d_dg_r[4] <= d_dg_r[3];
      d_dg_r[3] <= d_dg_r[2];
      d_dg_r[2] <= d_dg_r[1];
      d_dg_r[1] <= rem;
      d_dg_r[0] <= quo[6:0];
    end
  end

  always_comb begin
    e_full_nxt = e_full_r;
    e_idx_nxt  = e_idx_r;
    if (handoff) begin
      e_full_nxt = 1'b1;
      e_idx_nxt  = 3'd0;
    end else if (e_finish) begin
      e_full_nxt = 1'b0;
    end else if (e_full_r && out_load) begin
      e_idx_nxt  = e_idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_full_r <= 1'b0;
      e_idx_r  <= 3'd0;
    end else begin
      e_full_r <= e_full_nxt;
      e_idx_r  <= e_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      e_dg_r     <= d_dg_r;
      e_kind_r   <= d_kind_r;
      e_nchars_r <= d_nchars_r;
      e_char_r   <= d_char_r;
      e_end_r    <= d_end_r;
    end
  end

  assign e_digit    = e_dg_r[e_idx_r];
  assign e_out_char = (e_kind_r == JOB_DIGITS) ? b85_char(cfg.alphabet_select, e_digit)
                                               : e_char_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (e_full_r && out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (e_full_r && out_load) begin
      out_char_r        <= e_out_char;
      out_run_last_r    <= e_last;
      out_stream_done_r <= e_last && e_end_r;
      out_pad_error_r   <= (e_kind_r == JOB_ERROR);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_run_last    = out_run_last_r;
  assign out_stream_done = out_stream_done_r;
  assign out_pad_error   = out_pad_error_r;

endmodule

@@ design/base85_stream_encoder_core.sv @@
// Streaming base-85 encoder.
// Input channel (in_valid/in_ready): one raw byte per item, in_stream_end
// marks the last byte. Bytes gather into big-endian groups of four; each full
// group leaves as five characters (or one shortcut character for an enabled
// all-zero or all-space group), a final partial group of n bytes as n+1
// characters, or as one pad_error item when padding is disabled.
// Output channel (out_valid/out_ready): one character per item with
// run_last, stream_done and pad_error flags.
// Configuration: APB write/read of six registers at byte addresses 0..20.
// Throughput: one byte per cycle in while the queue has room, one character
// per cycle out while out_ready is high and the emitter holds a group. A full
// group occupies the reciprocal divider for four divide steps and the
// hand-off, and the emitter for its five characters.
// Reset (rst_n low, synchronous) clears the group being gathered, empties
// the queue and pipeline and loads the register defaults.
// When the receiver stalls, the output register holds its item, the emitter
// and divider fill up, then the queue, and in_ready drops.
module base85_stream_encoder_core
  import b85_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  // character output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_run_last,
  output logic        out_stream_done,
  output logic        out_pad_error
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t reg_idx;
  logic     cfg_write;
  logic     q_full;
  logic     q_empty;
  logic     q_push;
  logic     q_pop;
  job_t     push_job;
  job_t     pop_job;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Write registers; drop writes beyond the register list
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_write) begin
      case (reg_idx)
        REG_ALPHABET:   cfg_nxt.alphabet_select = pwdata[1:0];
        REG_ZERO_EN:    cfg_nxt.zero_en         = pwdata[0];
        REG_ZERO_CHAR:  cfg_nxt.zero_char       = pwdata[7:0];
        REG_SPACE_EN:   cfg_nxt.space_en        = pwdata[0];
        REG_SPACE_CHAR: cfg_nxt.space_char      = pwdata[7:0];
        REG_PADDING:    cfg_nxt.padding_en      = pwdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alphabet_select <= ALPHA_ORIGINAL;
      cfg_r.zero_en         <= 1'b1;
      cfg_r.zero_char       <= 8'd122;
      cfg_r.space_en        <= 1'b0;
      cfg_r.space_char      <= 8'd121;
      cfg_r.padding_en      <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      REG_ALPHABET:   prdata = {30'd0, cfg_r.alphabet_select};
      REG_ZERO_EN:    prdata = {31'd0, cfg_r.zero_en};
      REG_ZERO_CHAR:  prdata = {24'd0, cfg_r.zero_char};
      REG_SPACE_EN:   prdata = {31'd0, cfg_r.space_en};
      REG_SPACE_CHAR: prdata = {24'd0, cfg_r.space_char};
      REG_PADDING:    prdata = {31'd0, cfg_r.padding_en};
      default:        prdata = 32'd0;
    endcase
  end

  // Front end: gather bytes, classify finished groups
  b85_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_stream_end (in_stream_end),
    .q_full        (q_full),
    .push          (q_push),
    .push_job      (push_job)
  );

  // Decouple the front end from the digit pipeline
  b85_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // Back end: convert to base-85 digits and emit characters
  b85_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done),
    .out_pad_error   (out_pad_error)
  );

endmodule
